// ===== rtl/lue_pkg.sv =====
package lue_pkg;

   // URL length limit: a URL that would reach this length rejects the line
   localparam int MAX_URL_LEN = 512;
   localparam int CNT_W       = $clog2(MAX_URL_LEN);
   localparam int LEN_W       = 9;

   localparam logic [CNT_W-1:0] URL_LAST_OK = CNT_W'(MAX_URL_LEN - 1);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // parse phases
   localparam logic [2:0] PH_SKIP_FIELDS   = 3'd0;
   localparam logic [2:0] PH_WANT_LBRACKET = 3'd1;
   localparam logic [2:0] PH_IN_DATE       = 3'd2;
   localparam logic [2:0] PH_SKIP_ONE      = 3'd3;
   localparam logic [2:0] PH_WANT_QUOTE    = 3'd4;
   localparam logic [2:0] PH_METHOD        = 3'd5;
   localparam logic [2:0] PH_URL           = 3'd6;
   localparam logic [2:0] PH_DONE          = 3'd7;

   // result kinds
   localparam logic [1:0] KIND_URL    = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic             hit;
      logic [1:0]       kind;
      logic [7:0]       chr;
      logic [LEN_W-1:0] len;
      logic             last;
   } result_type;

endpackage

// ===== rtl/log_line_url_extractor_top.sv =====
// Access-log URL extractor. Takes one byte of a common-log-format line per
// item (req_line_end on the final byte) and returns the request URL bytes one
// per result item (kind URL), followed by a single verdict item: accepted
// with the URL length, or rejected on a format mismatch, an empty URL, a URL
// of MAX_URL_LEN bytes or more, or a line that ends before the URL's closing
// space. Bytes after the verdict give no result; each line end restarts the
// parser. Rate: one byte per clock cycle, sustained. Each byte is decoded by
// the parser's state logic in the cycle it is accepted and its result, if
// any, lands in a one-deep output register on the next edge; the input is
// stalled only while that register holds a result the consumer has not
// taken.
module log_line_url_extractor_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_line_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_url_char,
   output logic [8:0] rsp_url_length,
   output logic       rsp_verdict_last
);

   lue_pkg::result_type result;
   logic                item_fire;

   // output slot is free, or is being emptied this cycle
   assign req_ready = !rsp_valid || rsp_ready;
   assign item_fire = req_valid && req_ready;

   lue_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .line_byte (req_line_byte),
      .line_end  (req_line_end),
      .result    (result)
   );

   lue_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (item_fire && result.hit),
      .result    (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_kind  (rsp_result_kind),
      .out_chr   (rsp_url_char),
      .out_len   (rsp_url_length),
      .out_last  (rsp_verdict_last)
   );

endmodule

// ===== rtl/lue_parser.sv =====
module lue_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_fire,
   input  logic [7:0]          line_byte,
   input  logic                line_end,
   output lue_pkg::result_type result
);

   logic [2:0]               phase_ff, phase_in;
   logic [1:0]               spaces_ff, spaces_in;
   logic [lue_pkg::CNT_W-1:0] count_ff, count_in;

   logic       decided;
   logic       emit_url;
   logic [1:0] kind;

   always_comb begin
      phase_in  = phase_ff;
      spaces_in = spaces_ff;
      count_in  = count_ff;
      decided   = 1'b0;
      emit_url  = 1'b0;
      kind      = lue_pkg::KIND_REJECT;

      case (phase_ff)
         lue_pkg::PH_SKIP_FIELDS: begin
            if (line_byte == lue_pkg::CH_SPACE) begin
               spaces_in = spaces_ff + 2'd1;
               if (spaces_ff == 2'd2) begin
                  phase_in = lue_pkg::PH_WANT_LBRACKET;
               end
            end
         end
         lue_pkg::PH_WANT_LBRACKET: begin
            if (line_byte == lue_pkg::CH_LBRACK) begin
               phase_in = lue_pkg::PH_IN_DATE;
            end else begin
               decided = 1'b1;
            end
         end
         lue_pkg::PH_IN_DATE: begin
            if (line_byte == lue_pkg::CH_RBRACK) begin
               phase_in = lue_pkg::PH_SKIP_ONE;
            end
         end
         lue_pkg::PH_SKIP_ONE: begin
            phase_in = lue_pkg::PH_WANT_QUOTE;
         end
         lue_pkg::PH_WANT_QUOTE: begin
            if (line_byte == lue_pkg::CH_QUOTE) begin
               phase_in = lue_pkg::PH_METHOD;
            end else begin
               decided = 1'b1;
            end
         end
         lue_pkg::PH_METHOD: begin
            if (line_byte == lue_pkg::CH_SPACE) begin
               phase_in = lue_pkg::PH_URL;
            end
         end
         lue_pkg::PH_URL: begin
            if (line_byte == lue_pkg::CH_SPACE) begin
               decided = 1'b1;
               kind    = (count_ff == '0) ? lue_pkg::KIND_REJECT : lue_pkg::KIND_ACCEPT;
            end else if (line_end || count_ff >= lue_pkg::URL_LAST_OK) begin
               decided = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               emit_url = 1'b1;
            end
         end
         default: begin
            // verdict already given: rest of line is ignored
         end
      endcase

      // early line end rejects, unless this byte already decided
      if (phase_ff != lue_pkg::PH_DONE && !decided && line_end) begin
         decided  = 1'b1;
         emit_url = 1'b0;
      end

      if (decided) begin
         phase_in = lue_pkg::PH_DONE;
      end

      if (line_end) begin
         phase_in  = lue_pkg::PH_SKIP_FIELDS;
         spaces_in = '0;
         count_in  = '0;
      end

      result.hit  = decided || emit_url;
      result.kind = emit_url ? lue_pkg::KIND_URL : kind;
      result.chr  = emit_url ? line_byte : 8'd0;
      result.len  = (decided && kind == lue_pkg::KIND_ACCEPT)
                    ? lue_pkg::LEN_W'(count_ff) : '0;
      result.last = decided;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lue_pkg::PH_SKIP_FIELDS;
         spaces_ff <= '0;
         count_ff  <= '0;
      end else if (item_fire) begin
         phase_ff  <= phase_in;
         spaces_ff <= spaces_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/lue_out_reg.sv =====
module lue_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  lue_pkg::result_type result,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [1:0]          out_kind,
   output logic [7:0]          out_chr,
   output logic [lue_pkg::LEN_W-1:0] out_len,
   output logic                out_last
);

   logic                valid_ff;
   lue_pkg::result_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = data_ff.kind;
   assign out_chr   = data_ff.chr;
   assign out_len   = data_ff.len;
   assign out_last  = data_ff.last;

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
   localparam int HOLD_CYCLES  = 200;    // long receiver hold-off
   localparam int STREAM_BYTES = 2000;   // ~2000 bytes, the two long-URL lines included
   localparam int LONG_AT      = 500;    // long URL lines go in about here
   localparam int SHOW_MAX     = 10;

   typedef struct packed {
      logic [7:0] chr;
      logic       last;
   } line_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] chr;
      logic [8:0] len;
      logic       last;
   } url_result_type;

   // block inputs: all known from time zero
   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_line_byte = 8'h00;
   logic       req_line_end  = 1'b0;
   logic       rsp_ready     = 1'b0;

   logic       req_ready;
   logic       rsp_valid;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_url_char;
   logic [8:0] rsp_url_length;
   logic       rsp_verdict_last;

   log_line_url_extractor_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_byte    (req_line_byte),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_url_char     (rsp_url_char),
      .rsp_url_length   (rsp_url_length),
      .rsp_verdict_last (rsp_verdict_last)
   );

   always #5ns clock = ~clock;

   // byte stream waiting to go in, and the results it should produce
   line_item_type  log_stream[$];
   url_result_type url_results_due[$];
   logic [7:0]     line_buf[$];

   int bytes_taken   = 0;
   int total_bytes   = 0;
   int lines_built   = 0;
   int url_bytes_out = 0;
   int lines_ok      = 0;
   int lines_bad     = 0;
   int mismatches    = 0;
   int stall_cycles  = 0;
   int hold_left     = 0;
   logic hold_done   = 1'b0;
   int send_idle_pct;
   int recv_idle_pct;

   // ---------------------------------------------------------------------
   // Line parser mirror: tracks where in the log line we are and queues the
   // results each accepted byte should give.
   // ---------------------------------------------------------------------
   logic [2:0] line_phase   = lue_pkg::PH_SKIP_FIELDS;
   logic [1:0] field_spaces = 2'd0;
   logic [9:0] url_len      = 10'd0;
   logic       verdict_done = 1'b0;

   task automatic parse_byte(input logic [7:0] b, input logic eol);
      url_result_type r;
      logic           decided;
      logic [1:0]     kind;
      decided = 1'b0;
      kind    = lue_pkg::KIND_REJECT;
      if (!verdict_done) begin
         case (line_phase)
            lue_pkg::PH_SKIP_FIELDS: begin
               if (b == lue_pkg::CH_SPACE) begin
                  field_spaces = field_spaces + 2'd1;
                  if (field_spaces == 2'd3)
                     line_phase = lue_pkg::PH_WANT_LBRACKET;
               end
            end
            lue_pkg::PH_WANT_LBRACKET: begin
               if (b == lue_pkg::CH_LBRACK) line_phase = lue_pkg::PH_IN_DATE;
               else decided = 1'b1;
            end
            lue_pkg::PH_IN_DATE: begin
               if (b == lue_pkg::CH_RBRACK) line_phase = lue_pkg::PH_SKIP_ONE;
            end
            lue_pkg::PH_SKIP_ONE: line_phase = lue_pkg::PH_WANT_QUOTE;
            lue_pkg::PH_WANT_QUOTE: begin
               if (b == lue_pkg::CH_QUOTE) line_phase = lue_pkg::PH_METHOD;
               else decided = 1'b1;
            end
            lue_pkg::PH_METHOD: begin
               if (b == lue_pkg::CH_SPACE) line_phase = lue_pkg::PH_URL;
            end
            lue_pkg::PH_URL: begin
               if (b == lue_pkg::CH_SPACE) begin
                  decided = 1'b1;
                  kind    = (url_len == 10'd0) ? lue_pkg::KIND_REJECT : lue_pkg::KIND_ACCEPT;
               end else if (eol || int'(url_len) + 1 >= lue_pkg::MAX_URL_LEN) begin
                  // line end inside the URL, or URL would hit the length cap
                  decided = 1'b1;
               end else begin
                  url_len = url_len + 10'd1;
                  r.kind  = lue_pkg::KIND_URL;
                  r.chr   = b;
                  r.len   = 9'd0;
                  r.last  = 1'b0;
                  url_results_due.push_back(r);
               end
            end
            default: decided = 1'b1;
         endcase

         if (eol) decided = 1'b1;

         if (decided) begin
            r.kind  = kind;
            r.chr   = 8'h00;
            r.len   = (kind == lue_pkg::KIND_ACCEPT) ? url_len[8:0] : 9'd0;
            r.last  = 1'b1;
            url_results_due.push_back(r);
            verdict_done = 1'b1;
            line_phase   = lue_pkg::PH_DONE;
         end
      end

      // every line end starts the next line afresh
      if (eol) begin
         line_phase   = lue_pkg::PH_SKIP_FIELDS;
         field_spaces = 2'd0;
         url_len      = 10'd0;
         verdict_done = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Line builders
   // ---------------------------------------------------------------------
   function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
      logic [7:0] v;
      do v = 8'($urandom_range(255, 1)); while (v == avoid);
      return v;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   // well-formed line: ident fields, [date], one stray byte, "METHOD URL ...
   task automatic build_line(input int url_size);
      line_buf.delete();
      repeat (3) begin
         repeat ($urandom_range(4)) line_buf.push_back(pick_byte(lue_pkg::CH_SPACE));
         line_buf.push_back(lue_pkg::CH_SPACE);
      end
      line_buf.push_back(lue_pkg::CH_LBRACK);
      repeat ($urandom_range(6)) line_buf.push_back(pick_byte(lue_pkg::CH_RBRACK));
      line_buf.push_back(lue_pkg::CH_RBRACK);
      line_buf.push_back(pick_byte(8'h00));       // skipped whatever it is
      line_buf.push_back(lue_pkg::CH_QUOTE);
      repeat ($urandom_range(5)) line_buf.push_back(pick_byte(lue_pkg::CH_SPACE));
      line_buf.push_back(lue_pkg::CH_SPACE);
      repeat (url_size) line_buf.push_back(pick_byte(lue_pkg::CH_SPACE));
      line_buf.push_back(lue_pkg::CH_SPACE);
      repeat ($urandom_range(4)) line_buf.push_back(pick_byte(8'h00));
   endtask

   // move the built line onto the stream, flagging its last byte
   task automatic commit_line();
      line_item_type it;
      for (int i = 0; i < line_buf.size(); i++) begin
         it.chr  = line_buf[i];
         it.last = (i == line_buf.size() - 1);
         log_stream.push_back(it);
      end
      lines_built++;
   endtask

   // idling mix by progress: sender-light first, then receiver-light, then none
   always_comb begin
      if (bytes_taken < total_bytes / 3) begin
         send_idle_pct = 27;
         recv_idle_pct = 86;
      end else if (bytes_taken < 2 * total_bytes / 3) begin
         send_idle_pct = 86;
         recv_idle_pct = 27;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: predicts on each accepted byte, then offers the next one when
   // the slot is free. Valid holds with its payload until taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      line_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_line_byte, req_line_end);
            bytes_taken <= bytes_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (log_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = log_stream.pop_front();
               req_valid     <= 1'b1;
               req_line_byte <= nxt.chr;
               req_line_end  <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off late in the run, when the sender never idles,
   // so the one-deep result register fills and backs up the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && total_bytes != 0 && bytes_taken >= total_bytes * 5 / 6) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: each result item against the oldest one due
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      url_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (url_results_due.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= SHOW_MAX)
                  $display("%0t: stray result kind %0d char %02h len %0d last %0b", $realtime,
                           rsp_result_kind, rsp_url_char, rsp_url_length, rsp_verdict_last);
            end else begin
               want = url_results_due.pop_front();
               if (rsp_result_kind !== want.kind || rsp_url_char !== want.chr ||
                   rsp_url_length !== want.len || rsp_verdict_last !== want.last) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= SHOW_MAX)
                     $display({"%0t: kind %0d/%0d char %02h/%02h len %0d/%0d",
                               " last %0b/%0b (want/got)"},
                              $realtime, want.kind, rsp_result_kind, want.chr, rsp_url_char,
                              want.len, rsp_url_length, want.last, rsp_verdict_last);
               end
               case (want.kind)
                  lue_pkg::KIND_URL:    url_bytes_out = url_bytes_out + 1;
                  lue_pkg::KIND_ACCEPT: lines_ok      = lines_ok + 1;
                  default:              lines_bad     = lines_bad + 1;
               endcase
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog count: cycles since the last handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Stimulus and run control
   // ---------------------------------------------------------------------
   initial begin
      int   sel;
      int   n;
      int   pos;
      logic long_done;
      long_done = 1'b0;

      // directed lines
      // accept on a space that also ends the line; 0x01 after ']', URL 0xFF
      push_text("   []");
      line_buf.push_back(8'h01);
      push_text("\" ");
      line_buf.push_back(8'hFF);
      push_text(" ");
      commit_line();
      line_buf.delete();
      // empty URL (space straight after the method's space); ']' as stray byte
      push_text("   []]\"  ");
      commit_line();
      line_buf.delete();
      // '[' missing after the third field
      push_text("   x");
      commit_line();
      line_buf.delete();
      // quote missing after the stray byte
      push_text("   []ab");
      commit_line();

      // random lines, mostly well-formed with random content
      while (log_stream.size() < STREAM_BYTES) begin
         if (!long_done && log_stream.size() > LONG_AT) begin
            build_line(lue_pkg::MAX_URL_LEN - 1);     // longest URL still accepted
            commit_line();
            build_line(lue_pkg::MAX_URL_LEN);         // one byte too many
            commit_line();
            long_done = 1'b1;
         end
         sel = $urandom_range(99);
         build_line(($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1));
         if (sel >= 60 && sel < 75) begin
            // line ends early, anywhere
            n = $urandom_range(line_buf.size(), 1);
            while (line_buf.size() > n) void'(line_buf.pop_back());
         end else if (sel >= 75 && sel < 90) begin
            // one byte corrupted
            pos = $urandom_range(line_buf.size() - 1);
            line_buf[pos] = pick_byte(line_buf[pos]);
         end else if (sel >= 90) begin
            // noise, space-heavy so the field skipper moves
            line_buf.delete();
            repeat ($urandom_range(16, 1))
               line_buf.push_back(($urandom_range(2) == 0) ? lue_pkg::CH_SPACE
                                                           : pick_byte(8'h00));
         end
         commit_line();
      end
      total_bytes = log_stream.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while ((log_stream.size() != 0 || req_valid || url_results_due.size() != 0) &&
             stall_cycles < STALL_LIMIT)
         @(posedge clock);
      // run on to catch any stray result
      if (stall_cycles < STALL_LIMIT)
         repeat (8) @(posedge clock);

      if (stall_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results outstanding",
                  stall_cycles, url_results_due.size());
         $display("log_line_url_extractor_top: mismatch");
      end else begin
         $display("%0d bytes in %0d lines (incl. %0d- and %0d-byte URLs):",
                  bytes_taken, lines_built, lue_pkg::MAX_URL_LEN - 1, lue_pkg::MAX_URL_LEN);
         $display("  %0d URL bytes, %0d accepted, %0d rejected",
                  url_bytes_out, lines_ok, lines_bad);
         $display("idle mixes on both sides plus a %0d-cycle receiver hold-off; %0d mismatches",
                  HOLD_CYCLES, mismatches);
         if (mismatches == 0)
            $display("log_line_url_extractor_top: match");
         else
            $display("log_line_url_extractor_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lue_pkg.sv
rtl/lue_parser.sv
rtl/lue_out_reg.sv
rtl/log_line_url_extractor_top.sv
bench/tb.sv
